/* hw/rtl/bps_pkg.sv */
// Shared types, status codes and CRC helper for the BPS patch applier.
package bps_pkg;

  // Input word as it arrives on the item channel
  typedef struct packed {
    logic [1:0]  action;
    logic [7:0]  data_byte;
    logic        last_byte;
    logic [19:0] read_address;
  } item_t;

  // Result word on the result channel
  typedef struct packed {
    logic [3:0]  status;
    logic [7:0]  read_data;
    logic [20:0] target_size;
    logic [20:0] bytes_written;
  } result_t;

  // Raw action codes
  localparam logic [1:0] ACT_START  = 2'd0;
  localparam logic [1:0] ACT_SOURCE = 2'd1;
  localparam logic [1:0] ACT_PATCH  = 2'd2;
  localparam logic [1:0] ACT_READ   = 2'd3;

  // Classified operation handed from front to back
  typedef enum logic [1:0] {
    OP_START,
    OP_SOURCE,
    OP_PATCH,
    OP_READ
  } op_t;

  typedef struct packed {
    op_t         op;
    logic [7:0]  data;
    logic        last;
    logic [19:0] addr;
  } cmd_t;

  // Status codes
  localparam logic [3:0] ST_BUSY          = 4'd0;
  localparam logic [3:0] ST_DONE          = 4'd1;
  localparam logic [3:0] ST_BAD_MAGIC     = 4'd2;
  localparam logic [3:0] ST_TOO_SMALL     = 4'd3;
  localparam logic [3:0] ST_VARINT        = 4'd4;
  localparam logic [3:0] ST_TRUNCATED     = 4'd5;
  localparam logic [3:0] ST_META_INVALID  = 4'd6;
  localparam logic [3:0] ST_SOURCE_SIZE   = 4'd7;
  localparam logic [3:0] ST_TOO_LARGE     = 4'd8;
  localparam logic [3:0] ST_ILLEGAL_WRITE = 4'd9;
  localparam logic [3:0] ST_ILLEGAL_READ  = 4'd10;
  localparam logic [3:0] ST_RESULT_SIZE   = 4'd11;
  localparam logic [3:0] ST_PATCH_CRC     = 4'd12;
  localparam logic [3:0] ST_SOURCE_CRC    = 4'd13;
  localparam logic [3:0] ST_TARGET_CRC    = 4'd14;

  localparam logic [7:0]  VARINT_MSB = 8'h80;
  localparam logic [7:0]  VARINT_MAX = 8'hFF;
  localparam logic [7:0]  VARINT_NEAR_MAX = 8'hFE;
  localparam logic [31:0] CRC_POLY   = 32'hEDB88320;
  localparam int          WINDOW_LEN = 12;
  localparam int          MIN_PATCH  = 19;

  // Magic "BPS1", one byte per position
  function automatic logic [7:0] magic_byte(logic [1:0] idx);
    logic [7:0] b;
    case (idx)
      2'd0:    b = 8'h42;
      2'd1:    b = 8'h50;
      2'd2:    b = 8'h53;
      default: b = 8'h31;
    endcase
    return b;
  endfunction

  // Reflected CRC-32, one byte
  function automatic logic [31:0] crc_byte(logic [31:0] c, logic [7:0] b);
    logic [31:0] r;
    r = c ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
    end
    return r;
  endfunction

endpackage

/* hw/rtl/bps_delta_patch_apply.sv */
// Top level of the BPS delta patch applier.
// Usage: one item channel (item_valid/item_ready/item) and one result
// channel (result_valid/result_ready/result); every accepted word gives
// exactly one result word, in order.
// A start word clears the job: status busy, target store reads as zero
// (a fill count marks written bytes, so no clearing pass is needed).
// Source words load the source store; patch words follow, the last one
// flagged; read words return a target byte in read_data.
// SourceRead, SourceCopy and TargetCopy bytes are read and written one at a
// time through the single read port of each store; the last patch byte adds
// the trailer checks before its result word.
// A two-word queue in front keeps accepting while the back end works or a
// result waits; when the receiver stalls, the result register holds and
// the queue fills, then item_ready drops.
// Reset (rst, synchronous) empties the queue and clears the job as a start.
module bps_delta_patch_apply #(
  parameter int SOURCE_ADDR_BITS = 20,
  parameter int TARGET_ADDR_BITS = 20
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  output logic              item_ready,
  input  bps_pkg::item_t    item,
  output logic              result_valid,
  input  logic              result_ready,
  output bps_pkg::result_t  result
);

  logic          cmd_valid;
  bps_pkg::cmd_t cmd;
  logic          cmd_pop;

  bps_front u_front (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .item       (item),
    .cmd_valid  (cmd_valid),
    .cmd        (cmd),
    .cmd_pop    (cmd_pop)
  );

  bps_back #(
    .SOURCE_ADDR_BITS (SOURCE_ADDR_BITS),
    .TARGET_ADDR_BITS (TARGET_ADDR_BITS)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .cmd_valid    (cmd_valid),
    .cmd          (cmd),
    .cmd_pop      (cmd_pop),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

endmodule

/* hw/rtl/bps_ram.sv */
// Generic simple dual-port RAM with registered read.
module bps_ram #(
  parameter int WIDTH     = 8,
  parameter int ADDR_BITS = 8
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [ADDR_BITS-1:0] waddr,
  input  logic [WIDTH-1:0]     wdata,
  input  logic [ADDR_BITS-1:0] raddr,
  output logic [WIDTH-1:0]     rdata
);

  localparam longint DEPTH = 64'd1 << ADDR_BITS;

  logic [WIDTH-1:0] mem [0:DEPTH-1];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* hw/rtl/bps_front.sv */
// Front end: accepts input words, classifies them and queues them for the back end.
module bps_front (
  input  logic            clk,
  input  logic            rst,
  input  logic            item_valid,
  output logic            item_ready,
  input  bps_pkg::item_t  item,
  output logic            cmd_valid,
  output bps_pkg::cmd_t   cmd,
  input  logic            cmd_pop
);

  bps_pkg::cmd_t cls;
  bps_pkg::cmd_t slot [2];
  logic          wr_ptr;
  logic          rd_ptr;
  logic [1:0]    count;
  logic          push;

  // Classify the action; the last flag only counts on patch bytes
  always_comb begin
    cls.data = item.data_byte;
    cls.addr = item.read_address;
    cls.last = 1'b0;
    case (item.action)
      bps_pkg::ACT_START:  cls.op = bps_pkg::OP_START;
      bps_pkg::ACT_SOURCE: cls.op = bps_pkg::OP_SOURCE;
      bps_pkg::ACT_PATCH: begin
        cls.op   = bps_pkg::OP_PATCH;
        cls.last = item.last_byte;
      end
      default:             cls.op = bps_pkg::OP_READ;
    endcase
  end

  assign item_ready = (count != 2'd2);
  assign push       = item_valid && item_ready;
  assign cmd_valid  = (count != 2'd0);
  assign cmd        = slot[rd_ptr];

  // Two-entry queue
  always_ff @(posedge clk) begin
    if (push) begin
      slot[wr_ptr] <= cls;
    end
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (cmd_pop) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({push, cmd_pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

/* hw/rtl/bps_back.sv */
// Back end: parses the patch stream, runs copy commands and builds result words.
module bps_back #(
  parameter int SOURCE_ADDR_BITS = 20,
  parameter int TARGET_ADDR_BITS = 20
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cmd_valid,
  input  bps_pkg::cmd_t     cmd,
  output logic              cmd_pop,
  output logic              result_valid,
  input  logic              result_ready,
  output bps_pkg::result_t  result
);

  localparam int SA = SOURCE_ADDR_BITS;
  localparam int TA = TARGET_ADDR_BITS;
  localparam int SW = SA + 1;
  localparam int TW = TA + 1;
  localparam int PW = (SA > TA) ? SA : TA;
  localparam logic [SW-1:0] SrcCap = SW'(1) << SA;
  localparam logic [63:0]   TgtCap = 64'd1 << TA;

  // Command kinds from the opcode's low bits
  localparam logic [1:0] KIND_SREAD = 2'd0;
  localparam logic [1:0] KIND_TREAD = 2'd1;
  localparam logic [1:0] KIND_SCOPY = 2'd2;

  // Header field order
  localparam logic [1:0] HF_SOURCE = 2'd0;
  localparam logic [1:0] HF_TARGET = 2'd1;

  typedef enum logic [2:0] {
    PH_MAGIC,
    PH_HEADER,
    PH_META,
    PH_OPCODE,
    PH_OFFSET,
    PH_LITERAL
  } phase_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_READ_WAIT,
    S_PARSE,
    S_VDONE,
    S_SR_CHK,
    S_RC1,
    S_RC2,
    S_CP_RD,
    S_CP_WR,
    S_SHIFT,
    S_FIN,
    S_FIN_CRC,
    S_FIN_CHK,
    S_RESP
  } state_t;

  state_t            state;
  phase_t            phase;
  logic [3:0]        status;
  logic [7:0]        cur_data;
  logic              cur_last;
  logic [63:0]       vval;
  logic [3:0]        vidx;
  logic [1:0]        hfi;
  logic [63:0]       css;
  logic [TW-1:0]     cts;
  logic [63:0]       meta;
  logic [TW-1:0]     wp;
  logic [63:0]       scp;
  logic [63:0]       tcp;
  logic [1:0]        kind;
  logic [TW-1:0]     clen;
  logic [31:0]       pcrc;
  logic [31:0]       scrc;
  logic [31:0]       tcrc;
  logic [31:0]       fcrc;
  logic [SW-1:0]     scount;
  logic [4:0]        pcount;
  logic [7:0]        win [12];
  logic [PW-1:0]     rptr;
  logic              src_sel;
  logic              hit;
  logic [2:0]        fk;
  logic [7:0]        rd;
  bps_pkg::result_t  res;
  logic              res_valid;

  logic              job_clear;
  logic [7:0]        pbyte;
  logic [7:0]        y;
  logic [6:0]        vshift;
  logic [63:0]       vsum;
  logic              vbad;
  logic [TW-1:0]     diff;
  logic [63:0]       pos_sel;
  logic [63:0]       mag;
  logic              neg;
  logic [64:0]       adj;
  logic              rc1_err;
  logic [64:0]       end65;
  logic [63:0]       limit;
  logic              rc2_err;
  logic              sr_err;
  logic              hit_read;
  logic              hit_copy;
  logic [7:0]        copy_byte;
  logic [31:0]       word0;
  logic [31:0]       word4;
  logic [31:0]       word8;

  logic              src_we;
  logic [SA-1:0]     src_waddr;
  logic [7:0]        src_q;
  logic              tgt_we;
  logic [TA-1:0]     tgt_raddr;
  logic [7:0]        tgt_wdata;
  logic [7:0]        tgt_q;

  // Stores
  bps_ram #(.WIDTH(8), .ADDR_BITS(SA)) u_src_ram (
    .clk   (clk),
    .we    (src_we),
    .waddr (src_waddr),
    .wdata (cmd.data),
    .raddr (rptr[SA-1:0]),
    .rdata (src_q)
  );

  bps_ram #(.WIDTH(8), .ADDR_BITS(TA)) u_tgt_ram (
    .clk   (clk),
    .we    (tgt_we),
    .waddr (wp[TA-1:0]),
    .wdata (tgt_wdata),
    .raddr (tgt_raddr),
    .rdata (tgt_q)
  );

  assign cmd_pop   = (state == S_IDLE) && cmd_valid;
  assign job_clear = rst || (cmd_pop && cmd.op == bps_pkg::OP_START);

  // Store port control
  always_comb begin
    src_we    = cmd_pop && cmd.op == bps_pkg::OP_SOURCE && status == bps_pkg::ST_BUSY &&
                scount != SrcCap;
    src_waddr = scount[SA-1:0];
    tgt_we    = (state == S_PARSE && phase == PH_LITERAL) || state == S_CP_WR;
    tgt_wdata = (state == S_PARSE) ? pbyte : copy_byte;
    tgt_raddr = (state == S_IDLE) ? TA'(cmd.addr) : rptr[TA-1:0];
  end

  // Varint step, copy address math and trailer words
  always_comb begin
    pbyte     = win[0];
    y         = pbyte ^ bps_pkg::VARINT_MSB;
    vshift    = 7'(vidx) * 7'd7;
    vsum      = vval + (64'(y) << vshift);
    vbad      = (vidx > 4'd9) ||
                (vidx == 4'd8 && (y == bps_pkg::VARINT_MAX ||
                                  (y == bps_pkg::VARINT_NEAR_MAX && !vsum[63]))) ||
                (vidx == 4'd9 && y != 8'd0);
    diff      = cts - wp;
    pos_sel   = (kind == KIND_SCOPY) ? scp : tcp;
    mag       = {1'b0, vval[63:1]};
    neg       = vval[0];
    adj       = {1'b0, pos_sel} + {1'b0, (neg ? ~mag : mag)} + 65'(neg);
    rc1_err   = neg ? !adj[64] : adj[64];
    end65     = {1'b0, pos_sel} + 65'(clen);
    limit     = (kind == KIND_SCOPY) ? css : 64'(cts);
    rc2_err   = end65[64] || (end65[63:0] > limit);
    sr_err    = (64'(wp) + 64'(clen)) > css;
    hit_read  = 64'(cmd.addr) < 64'(wp);
    hit_copy  = 64'(rptr) < 64'(wp);
    copy_byte = src_sel ? src_q : (hit ? tgt_q : 8'd0);
    word0     = {win[3], win[2], win[1], win[0]};
    word4     = {win[7], win[6], win[5], win[4]};
    word8     = {win[11], win[10], win[9], win[8]};
  end

  assign result_valid = res_valid;
  assign result       = res;

  // Sequencer and job state
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      res_valid <= 1'b0;
    end else begin
      if (result_ready && state != S_RESP) begin
        res_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (cmd_valid) begin
            rd       <= 8'd0;
            cur_data <= cmd.data;
            cur_last <= cmd.last;
            case (cmd.op)
              bps_pkg::OP_START: state <= S_RESP;
              bps_pkg::OP_SOURCE: begin
                if (status == bps_pkg::ST_BUSY) begin
                  if (scount == SrcCap) begin
                    status <= bps_pkg::ST_TOO_LARGE;
                  end else begin
                    scrc   <= bps_pkg::crc_byte(scrc, cmd.data);
                    scount <= scount + SW'(1);
                  end
                end
                state <= S_RESP;
              end
              bps_pkg::OP_PATCH: begin
                if (status != bps_pkg::ST_BUSY) begin
                  state <= S_RESP;
                end else if (pcount >= 5'(bps_pkg::WINDOW_LEN)) begin
                  pcrc  <= bps_pkg::crc_byte(pcrc, win[0]);
                  state <= S_PARSE;
                end else begin
                  state <= S_SHIFT;
                end
              end
              default: begin
                hit   <= hit_read;
                state <= S_READ_WAIT;
              end
            endcase
          end
        end

        S_READ_WAIT: begin
          rd    <= hit ? tgt_q : 8'd0;
          state <= S_RESP;
        end

        // One byte out of the trailer window into the parser
        S_PARSE: begin
          state <= (phase inside {PH_HEADER, PH_OPCODE, PH_OFFSET} && !vbad && !y[7]) ?
                   S_VDONE : S_SHIFT;
          case (phase)
            PH_MAGIC: begin
              if (vidx > 4'd3 || pbyte != bps_pkg::magic_byte(vidx[1:0])) begin
                status <= bps_pkg::ST_BAD_MAGIC;
              end else if (vidx == 4'd3) begin
                phase <= PH_HEADER;
                hfi   <= HF_SOURCE;
                vval  <= 64'd0;
                vidx  <= 4'd0;
              end else begin
                vidx <= vidx + 4'd1;
              end
            end
            PH_HEADER, PH_OPCODE, PH_OFFSET: begin
              vval <= vsum;
              if (vbad) begin
                status <= bps_pkg::ST_VARINT;
              end else if (!y[7]) begin
                vidx <= 4'd0;
              end else begin
                vidx <= vidx + 4'd1;
              end
            end
            PH_META: begin
              meta <= meta - 64'd1;
              if (meta == 64'd1) begin
                if (css != 64'(scount)) begin
                  status <= bps_pkg::ST_SOURCE_SIZE;
                end else begin
                  phase <= PH_OPCODE;
                  vval  <= 64'd0;
                  vidx  <= 4'd0;
                end
              end
            end
            PH_LITERAL: begin
              tcrc <= bps_pkg::crc_byte(tcrc, pbyte);
              wp   <= wp + TW'(1);
              clen <= clen - TW'(1);
              if (clen == TW'(1)) begin
                phase <= PH_OPCODE;
                vval  <= 64'd0;
                vidx  <= 4'd0;
              end
            end
            default: status <= bps_pkg::ST_TRUNCATED;
          endcase
        end

        // A varint completed
        S_VDONE: begin
          case (phase)
            PH_HEADER: begin
              vval  <= 64'd0;
              hfi   <= hfi + 2'd1;
              state <= S_SHIFT;
              case (hfi)
                HF_SOURCE: css <= vval;
                HF_TARGET: begin
                  if (vval > TgtCap) begin
                    status <= bps_pkg::ST_TOO_LARGE;
                  end else begin
                    cts <= TW'(vval);
                  end
                end
                default: begin
                  meta <= vval;
                  if (vval == 64'd0) begin
                    if (css != 64'(scount)) begin
                      status <= bps_pkg::ST_SOURCE_SIZE;
                    end else begin
                      phase <= PH_OPCODE;
                    end
                  end else begin
                    phase <= PH_META;
                  end
                end
              endcase
            end
            PH_OPCODE: begin
              // length - 1 must stay below the room left
              if (vval[63:2] >= 62'(diff)) begin
                status <= bps_pkg::ST_ILLEGAL_WRITE;
                state  <= S_SHIFT;
              end else begin
                clen <= TW'(vval[63:2]) + TW'(1);
                kind <= vval[1:0];
                vval <= 64'd0;
                case (vval[1:0])
                  KIND_SREAD: state <= S_SR_CHK;
                  KIND_TREAD: begin
                    phase <= PH_LITERAL;
                    state <= S_SHIFT;
                  end
                  default: begin
                    phase <= PH_OFFSET;
                    state <= S_SHIFT;
                  end
                endcase
              end
            end
            default: state <= S_RC1;
          endcase
        end

        S_SR_CHK: begin
          if (sr_err) begin
            status <= bps_pkg::ST_ILLEGAL_READ;
            state  <= S_SHIFT;
          end else begin
            rptr    <= PW'(wp);
            src_sel <= 1'b1;
            state   <= S_CP_RD;
          end
        end

        // Apply the signed relative offset
        S_RC1: begin
          if (rc1_err) begin
            status <= bps_pkg::ST_ILLEGAL_READ;
            state  <= S_SHIFT;
          end else begin
            if (kind == KIND_SCOPY) begin
              scp <= adj[63:0];
            end else begin
              tcp <= adj[63:0];
            end
            state <= S_RC2;
          end
        end

        // Bound the copied range, then start the walk
        S_RC2: begin
          if (rc2_err) begin
            status <= bps_pkg::ST_ILLEGAL_READ;
            state  <= S_SHIFT;
          end else begin
            rptr <= PW'(pos_sel);
            if (kind == KIND_SCOPY) begin
              scp <= end65[63:0];
            end else begin
              tcp <= end65[63:0];
            end
            src_sel <= (kind == KIND_SCOPY);
            phase   <= PH_OPCODE;
            vval    <= 64'd0;
            vidx    <= 4'd0;
            state   <= S_CP_RD;
          end
        end

        S_CP_RD: begin
          hit   <= hit_copy;
          state <= S_CP_WR;
        end

        S_CP_WR: begin
          tcrc  <= bps_pkg::crc_byte(tcrc, copy_byte);
          wp    <= wp + TW'(1);
          rptr  <= rptr + PW'(1);
          clen  <= clen - TW'(1);
          state <= (clen == TW'(1)) ? S_SHIFT : S_CP_RD;
        end

        // Push the new patch byte into the trailer window
        S_SHIFT: begin
          for (int i = 0; i < 11; i++) begin
            win[i] <= win[i+1];
          end
          win[11] <= cur_data;
          if (pcount != 5'h1F) begin
            pcount <= pcount + 5'd1;
          end
          state <= cur_last ? S_FIN : S_RESP;
        end

        S_FIN: begin
          if (status != bps_pkg::ST_BUSY) begin
            state <= S_RESP;
          end else if (pcount < 5'(bps_pkg::MIN_PATCH)) begin
            status <= bps_pkg::ST_TOO_SMALL;
            state  <= S_RESP;
          end else begin
            fcrc  <= pcrc;
            fk    <= 3'd0;
            state <= S_FIN_CRC;
          end
        end

        // Trailer's two CRC words count toward the patch CRC
        S_FIN_CRC: begin
          fcrc <= bps_pkg::crc_byte(fcrc, win[{1'b0, fk}]);
          fk   <= fk + 3'd1;
          if (fk == 3'd7) begin
            state <= S_FIN_CHK;
          end
        end

        S_FIN_CHK: begin
          if (~fcrc != word8) begin
            status <= bps_pkg::ST_PATCH_CRC;
          end else if (phase == PH_META) begin
            status <= bps_pkg::ST_META_INVALID;
          end else if (phase == PH_LITERAL) begin
            status <= bps_pkg::ST_ILLEGAL_READ;
          end else if (phase != PH_OPCODE || vidx != 4'd0) begin
            status <= bps_pkg::ST_TRUNCATED;
          end else if (~scrc != word0) begin
            status <= bps_pkg::ST_SOURCE_CRC;
          end else if (wp != cts) begin
            status <= bps_pkg::ST_RESULT_SIZE;
          end else if (~tcrc != word4) begin
            status <= bps_pkg::ST_TARGET_CRC;
          end else begin
            status <= bps_pkg::ST_DONE;
          end
          state <= S_RESP;
        end

        S_RESP: begin
          if (!res_valid || result_ready) begin
            res_valid         <= 1'b1;
            res.status        <= status;
            res.read_data     <= rd;
            res.target_size   <= 21'(cts);
            res.bytes_written <= 21'(wp);
            state             <= S_IDLE;
          end
        end

        default: state <= S_IDLE;
      endcase
    end

    // Reset or start word clears the job
    if (job_clear) begin
      phase  <= PH_MAGIC;
      status <= bps_pkg::ST_BUSY;
      vval   <= 64'd0;
      vidx   <= 4'd0;
      hfi    <= HF_SOURCE;
      css    <= 64'd0;
      cts    <= '0;
      meta   <= 64'd0;
      wp     <= '0;
      scp    <= 64'd0;
      tcp    <= 64'd0;
      kind   <= KIND_SREAD;
      clen   <= '0;
      pcrc   <= '1;
      scrc   <= '1;
      tcrc   <= '1;
      scount <= '0;
      pcount <= 5'd0;
      for (int i = 0; i < 12; i++) begin
        win[i] <= 8'd0;
      end
    end
  end

endmodule

/* hw/rtl/bps_checker.sv */
// Port-level checks for the BPS patch applier, bound to the top level.
module bps_checker (
  input logic              clk,
  input logic              rst,
  input logic              item_valid,
  input logic              item_ready,
  input bps_pkg::item_t    item,
  input logic              result_valid,
  input logic              result_ready,
  input bps_pkg::result_t  result
);

  // A stalled result word holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid && $stable(result))
    else $error("result word changed while stalled");

  // A waiting input word holds
  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    item_valid && !item_ready |=> item_valid && $stable(item))
    else $error("input word changed while waiting");

  // Nothing pending right after reset
  a_reset: assert property (@(posedge clk) rst |=> !result_valid)
    else $error("result valid after reset");

  // Status never takes an undefined code
  a_status: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> result.status <= bps_pkg::ST_TARGET_CRC)
    else $error("undefined status code");

  // Writes never run past the claimed target length
  a_bounds: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> result.bytes_written <= result.target_size)
    else $error("bytes written beyond target size");

endmodule

bind bps_delta_patch_apply bps_checker u_bps_checker (
  .clk          (clk),
  .rst          (rst),
  .item_valid   (item_valid),
  .item_ready   (item_ready),
  .item         (item),
  .result_valid (result_valid),
  .result_ready (result_ready),
  .result       (result)
);
